@@ rtl/ppc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ppc_pkg;
  localparam int PaletteMax   = 8;
  localparam int SatFracBits  = 10;
  localparam int IdxW         = 3;
  localparam int DistW        = 18;
  localparam int SatW         = SatFracBits + 1;

  typedef enum logic [2:0] {
    REG_PAIR_A   = 3'd0,
    REG_PAIR_B   = 3'd1,
    REG_PAIR_C   = 3'd2,
    REG_PAIR_D   = 3'd3,
    REG_COUNT    = 3'd4,
    REG_BRIGHT   = 3'd5,
    REG_SAT      = 3'd6,
    REG_UNUSED   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t [PaletteMax-1:0] pal;
    logic [3:0]            count;
    logic [7:0]            bthr;
    logic [SatW-1:0]       sthr;
  } cfg_t;

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    absdiff8 = (a > b) ? (a - b) : (b - a);
  endfunction
endpackage
`default_nettype wire

@@ rtl/ppc_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ppc_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [47:0]  cfg_data_i,
  output ppc_pkg::cfg_t     cfg_o
);
  import ppc_pkg::*;

  logic [47:0]     pair_q [4];
  logic [3:0]      count_q;
  logic [7:0]      bthr_q;
  logic [SatW-1:0] sthr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) pair_q[k] <= '0;
      count_q <= 4'd6;
      bthr_q  <= 8'd64;
      sthr_q  <= SatW'(205);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PAIR_A: pair_q[0] <= cfg_data_i;
        REG_PAIR_B: pair_q[1] <= cfg_data_i;
        REG_PAIR_C: pair_q[2] <= cfg_data_i;
        REG_PAIR_D: pair_q[3] <= cfg_data_i;
        REG_COUNT:  count_q   <= cfg_data_i[3:0];
        REG_BRIGHT: bthr_q    <= cfg_data_i[7:0];
        REG_SAT:    sthr_q    <= cfg_data_i[SatW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < PaletteMax; k++) begin
      cfg_o.pal[k] = pair_q[k/2][(k%2)*24 +: 24];
    end
    cfg_o.count = count_q;
    cfg_o.bthr  = bthr_q;
    cfg_o.sthr  = sthr_q;
  end
endmodule
`default_nettype wire

@@ rtl/ppc_sat_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: (diff << SatFracBits) / mx, one quotient
// bit per stage. Side data rides along; all stages advance on en_i.
module ppc_sat_div (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [7:0]       diff_i,
  input  wire logic [7:0]       mx_i,
  output logic [ppc_pkg::SatW-1:0] sat_o
);
  import ppc_pkg::*;

  localparam int NumBits = SatFracBits + 8;
  localparam int RemW    = 9;

  logic [NumBits-1:0] num_q [NumBits+1];
  logic [RemW-1:0]    rem_q [NumBits+1];
  logic [7:0]         den_q [NumBits+1];
  logic [NumBits-1:0] quo_q [NumBits+1];

  always_comb begin
    num_q[0] = {diff_i, SatFracBits'(0)};
    rem_q[0] = '0;
    den_q[0] = mx_i;
    quo_q[0] = '0;
  end

  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [RemW-1:0] trial;
    logic            ge;
    assign trial = {rem_q[s][RemW-2:0], num_q[s][NumBits-1-s]};
    assign ge    = trial >= {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        rem_q[s+1] <= ge ? (trial - {1'b0, den_q[s]}) : trial;
        quo_q[s+1] <= quo_q[s] | (NumBits'(ge) << (NumBits-1-s));
      end
    end
  end

  // diff <= mx, so the quotient never exceeds 2^SatFracBits.
  assign sat_o = (den_q[NumBits] == 8'd0) ? '0 : quo_q[NumBits][SatW-1:0];
endmodule
`default_nettype wire

@@ rtl/ppc_nearest.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Squared distance to every palette entry, then a registered argmin tree.
module ppc_nearest (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  ppc_pkg::rgb_t        pix_i,
  input  ppc_pkg::cfg_t        cfg_i,
  output logic [ppc_pkg::IdxW-1:0] idx_o
);
  import ppc_pkg::*;

  logic [DistW-1:0] d_q [PaletteMax];
  logic [3:0]       n;
  logic [DistW-1:0] l1d_q [4];
  logic [IdxW-1:0]  l1i_q [4];
  logic [DistW-1:0] l2d_q [2];
  logic [IdxW-1:0]  l2i_q [2];
  logic [IdxW-1:0]  idx_q;

  always_comb begin
    n = cfg_i.count;
    if (n < 4'd2) n = 4'd2;
    if (n > 4'(PaletteMax)) n = 4'(PaletteMax);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < PaletteMax; k++) begin
        logic [7:0] dr, dg, db;
        dr = absdiff8(pix_i.r, cfg_i.pal[k].r);
        dg = absdiff8(pix_i.g, cfg_i.pal[k].g);
        db = absdiff8(pix_i.b, cfg_i.pal[k].b);
        // Unused entries get the maximum distance and lose every tie.
        d_q[k] <= (4'(k) < n) ? (DistW'(dr*dr) + DistW'(dg*dg) + DistW'(db*db))
                              : '1;
      end
      for (int k = 0; k < 4; k++) begin
        if (d_q[2*k+1] < d_q[2*k]) begin
          l1d_q[k] <= d_q[2*k+1];
          l1i_q[k] <= IdxW'(2*k+1);
        end else begin
          l1d_q[k] <= d_q[2*k];
          l1i_q[k] <= IdxW'(2*k);
        end
      end
      for (int k = 0; k < 2; k++) begin
        if (l1d_q[2*k+1] < l1d_q[2*k]) begin
          l2d_q[k] <= l1d_q[2*k+1];
          l2i_q[k] <= l1i_q[2*k+1];
        end else begin
          l2d_q[k] <= l1d_q[2*k];
          l2i_q[k] <= l1i_q[2*k];
        end
      end
      idx_q <= (l2d_q[1] < l2d_q[0]) ? l2i_q[1] : l2i_q[0];
    end
  end

  assign idx_o = idx_q;
endmodule
`default_nettype wire

@@ rtl/palette_pixel_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Palette pixel classifier.
// Input beats carry one RGB pixel plus an end-of-frame flag; each input beat
// yields exactly one output beat with the palette index (zero for background
// pixels), the foreground flag and the copied end-of-frame flag, in order.
// The datapath is one pipeline of Lat = 19 stages: a min/max stage, an
// 18-stage restoring divider for saturation, and in parallel a distance
// stage and a three-level argmin tree whose result waits in a delay line.
// A new beat is taken every cycle unless in_stall_o is high; each beat passes
// through all pipeline stages and then into the output register.
// The whole pipeline, output register included, advances only when the
// output register is empty or is being taken, so in_stall_o follows
// out_stall_i when the output is full; nothing is lost or repeated.
// Configuration writes go straight to registers and must be done while the
// pipeline is empty. Reset clears all valid bits and loads the register
// defaults: all palette entries black, count 6, thresholds 64 and 205.
module palette_pixel_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  pixel_red_i,
  input  wire logic [7:0]  pixel_green_i,
  input  wire logic [7:0]  pixel_blue_i,
  input  wire logic        end_of_frame_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       color_index_o,
  output logic             is_foreground_o,
  output logic             last_pixel_o
);
  import ppc_pkg::*;

  localparam int DivLat = SatFracBits + 8;
  localparam int Lat    = DivLat + 1;

  cfg_t cfg;
  logic en;
  logic [Lat-1:0] vld_q;
  logic [Lat-1:0] eof_q;
  logic [7:0] pmx_q, pdiff_q, bmx_q, bdiff_q;
  logic [7:0] pv_q [Lat];
  logic [7:0] bv_q [Lat];
  logic [IdxW-1:0] nidx;
  logic [IdxW-1:0] idx_q [Lat];
  logic [SatW-1:0] ps, bs, sd;
  logic [7:0] vd;
  logic fg;
  logic out_valid_q;
  logic [2:0] out_idx_q;
  logic out_fg_q, out_eof_q;
  rgb_t pix;
  logic [7:0] pmx, pmn, bmx, bmn;

  ppc_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  assign en = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign pix = '{r: pixel_red_i, g: pixel_green_i, b: pixel_blue_i};

  always_comb begin
    pmx = (pix.r > pix.g) ? pix.r : pix.g;
    pmx = (pmx > pix.b) ? pmx : pix.b;
    pmn = (pix.r < pix.g) ? pix.r : pix.g;
    pmn = (pmn < pix.b) ? pmn : pix.b;
    bmx = (cfg.pal[0].r > cfg.pal[0].g) ? cfg.pal[0].r : cfg.pal[0].g;
    bmx = (bmx > cfg.pal[0].b) ? bmx : cfg.pal[0].b;
    bmn = (cfg.pal[0].r < cfg.pal[0].g) ? cfg.pal[0].r : cfg.pal[0].g;
    bmn = (bmn < cfg.pal[0].b) ? bmn : cfg.pal[0].b;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pmx_q   <= pmx;
      pdiff_q <= pmx - pmn;
      bmx_q   <= bmx;
      bdiff_q <= bmx - bmn;
    end
  end

  ppc_sat_div u_pdiv (.clk_i, .en_i(en), .diff_i(pdiff_q), .mx_i(pmx_q), .sat_o(ps));
  ppc_sat_div u_bdiv (.clk_i, .en_i(en), .diff_i(bdiff_q), .mx_i(bmx_q), .sat_o(bs));
  ppc_nearest u_near (.clk_i, .en_i(en), .pix_i(pix), .cfg_i(cfg), .idx_o(nidx));

  // Side data delay lines. Stage 0 is the min/max register; the nearest
  // index appears after four stages and is carried on from there.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pv_q[0]  <= pmx;
      bv_q[0]  <= bmx;
      idx_q[0] <= '0;
      for (int k = 1; k < Lat; k++) begin
        pv_q[k] <= pv_q[k-1];
        bv_q[k] <= bv_q[k-1];
        idx_q[k] <= (k == 4) ? nidx : idx_q[k-1];
      end
      eof_q <= {eof_q[Lat-2:0], end_of_frame_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Lat-2:0], in_valid_i};
      out_valid_q <= vld_q[Lat-1];
    end
  end

  assign vd = absdiff8(pv_q[Lat-1], bv_q[Lat-1]);
  assign sd = (ps > bs) ? (ps - bs) : (bs - ps);
  assign fg = (vd >= cfg.bthr) || (sd >= cfg.sthr);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_idx_q <= fg ? idx_q[Lat-1] : '0;
      out_fg_q  <= fg;
      out_eof_q <= eof_q[Lat-1];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign color_index_o   = out_idx_q;
  assign is_foreground_o = out_fg_q;
  assign last_pixel_o    = out_eof_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("spurious stall");
  a_bg_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_foreground_o) |-> (color_index_o == 3'd0))
    else $error("background pixel with nonzero index");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(color_index_o)))
    else $error("output changed under stall");
endmodule
`default_nettype wire
